// ----- src/tq_pkg.sv -----
// tq_pkg: shared types and constants for the team queue.
// Word layouts between front, back and result queue, action codes, engine states.
// No dependencies.
package tq_pkg;

	localparam int ELEM_W       = 10;
	localparam int TEAM_W       = 10;
	localparam int CNT_W        = 11;
	localparam int LEN_W        = 11;
	localparam int ELEMENTS_DEF = 1024;
	localparam int TEAMS_DEF    = 1024;

	localparam logic [LEN_W-1:0] QLEN_MAX  = LEN_W'(2047);
	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2047);

	localparam logic [1:0] ACT_ASSIGN  = 2'd0;
	localparam logic [1:0] ACT_ENQUEUE = 2'd1;
	localparam logic [1:0] ACT_DEQUEUE = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ASSIGN,
		OP_ENQ,
		OP_DEQ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ELEM_W-1:0] element;
		logic [TEAM_W-1:0] team;
	} cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0] out_element;
		logic              was_empty;
	} res_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ENQ_LOOK,
		ST_ENQ_LINK,
		ST_ENQ_FIX,
		ST_ENQ_SPLICE,
		ST_DEQ_LOOK,
		ST_DEQ_DONE
	} state_t;

endpackage

// ----- src/tq_front.sv -----
// tq_front: input side; decodes each word, range-checks assign and enqueue operands, holds two commands.
// Depends on tq_pkg.
module tq_front #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                action,
	input  logic [tq_pkg::ELEM_W-1:0] element,
	input  logic [tq_pkg::TEAM_W-1:0] team,
	input  logic                      busy,
	output logic                      cmd_valid,
	output tq_pkg::cmd_t              cmd,
	input  logic                      cmd_pop
);
	import tq_pkg::*;

	cmd_t       slot_q [2];
	cmd_t       cmd_in;
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       wr;
	logic       rd;
	logic       elem_ok;
	logic       team_ok;

	assign elem_ok = 32'(element) < ELEMENTS;
	assign team_ok = 32'(team) < TEAMS;

	always_comb begin
		cmd_in.element = element;
		cmd_in.team    = team;
		unique case (action)
			ACT_ASSIGN:  cmd_in.op = (elem_ok && team_ok) ? OP_ASSIGN : OP_NOP;
			ACT_ENQUEUE: cmd_in.op = elem_ok ? OP_ENQ : OP_NOP;
			ACT_DEQUEUE: cmd_in.op = OP_DEQ;
			ACT_CLEAR:   cmd_in.op = OP_CLEAR;
			default:     cmd_in.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2) || busy;
	assign wr        = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign rd        = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
		end
	end

endmodule

// ----- src/tq_back.sv -----
// tq_back: list engine; owns the membership, link, team tail and team count stores.
// Runs one command at a time; sweeps membership and counts after reset and clear.
// Depends on tq_pkg.
module tq_back #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  tq_pkg::cmd_t cmd,
	output logic         cmd_pop,
	output logic         busy,
	input  logic         res_full,
	output logic         res_push,
	output tq_pkg::res_t res
);
	import tq_pkg::*;

	localparam int EW   = $clog2(ELEMENTS);
	localparam int TW   = $clog2(TEAMS);
	localparam int MAXD = (ELEMENTS > TEAMS) ? ELEMENTS : TEAMS;
	localparam int SW   = $clog2(MAXD);

	logic [ELEM_W-1:0] team_of_mem   [ELEMENTS];
	logic [ELEM_W-1:0] next_link_mem [ELEMENTS];
	logic [ELEM_W-1:0] team_tail_mem [TEAMS];
	logic [CNT_W-1:0]  team_count_mem [TEAMS];

	logic              to_we, nl_we, tt_we, tc_we;
	logic [EW-1:0]     to_wa, to_ra, nl_wa, nl_ra;
	logic [TW-1:0]     tt_wa, tt_ra, tc_wa, tc_ra;
	logic [TEAM_W-1:0] to_wd, to_rd;
	logic [ELEM_W-1:0] nl_wd, nl_rd, tt_wd, tt_rd;
	logic [CNT_W-1:0]  tc_wd, tc_rd;

	state_t            state_q, state_d;
	logic [ELEM_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [ELEM_W-1:0] x_q, x_d, y_q, y_d, nxt_q, nxt_d;
	logic [TEAM_W-1:0] t_q, t_d;
	logic [SW-1:0]     sweep_q, sweep_d;
	logic              t_valid;
	logic              ins;
	logic              sweep_end;

	always_ff @(posedge clk) begin
		if (to_we) begin
			team_of_mem[to_wa] <= to_wd;
		end
		to_rd <= team_of_mem[to_ra];
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			next_link_mem[nl_wa] <= nl_wd;
		end
		nl_rd <= next_link_mem[nl_ra];
	end

	always_ff @(posedge clk) begin
		if (tt_we) begin
			team_tail_mem[tt_wa] <= tt_wd;
		end
		tt_rd <= team_tail_mem[tt_ra];
	end

	always_ff @(posedge clk) begin
		if (tc_we) begin
			team_count_mem[tc_wa] <= tc_wd;
		end
		tc_rd <= team_count_mem[tc_ra];
	end

	assign t_valid   = (t_q != '0) && (32'(t_q) < TEAMS);
	assign ins       = t_valid && (tc_rd != '0) && (len_q != '0) && (tt_rd != tail_q);
	assign sweep_end = sweep_q == SW'(MAXD - 1);
	assign busy      = state_q == ST_SWEEP;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && ((cmd.op != OP_DEQ) || !res_full);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_pop) begin
					unique case (cmd.op)
						OP_ENQ: begin
							if (len_q < QLEN_MAX) begin
								state_d = ST_ENQ_LOOK;
							end
						end
						OP_DEQ: begin
							if (len_q != '0) begin
								state_d = ST_DEQ_LOOK;
							end
						end
						OP_CLEAR: state_d = ST_SWEEP;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENQ_LOOK:   state_d = ST_ENQ_LINK;
			ST_ENQ_LINK:   state_d = ins ? ST_ENQ_FIX : ST_IDLE;
			ST_ENQ_FIX:    state_d = ST_ENQ_SPLICE;
			ST_ENQ_SPLICE: state_d = ST_IDLE;
			ST_DEQ_LOOK:   state_d = ST_DEQ_DONE;
			ST_DEQ_DONE:   state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		to_we = 1'b0; to_wa = '0; to_wd = '0; to_ra = '0;
		nl_we = 1'b0; nl_wa = '0; nl_wd = '0; nl_ra = '0;
		tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = '0;
		tc_we = 1'b0; tc_wa = '0; tc_wd = '0; tc_ra = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		len_d    = len_q;
		x_d      = x_q;
		y_d      = y_q;
		t_d      = t_q;
		nxt_d    = nxt_q;
		sweep_d  = sweep_q;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ST_SWEEP: begin
				to_we   = 32'(sweep_q) < ELEMENTS;
				to_wa   = EW'(sweep_q);
				tc_we   = 32'(sweep_q) < TEAMS;
				tc_wa   = TW'(sweep_q);
				sweep_d = sweep_q + SW'(1);
			end
			ST_IDLE: begin
				to_ra = (cmd.op == OP_ENQ) ? EW'(cmd.element) : EW'(head_q);
				nl_ra = EW'(head_q);
				x_d   = cmd.element;
				if (cmd_pop) begin
					unique case (cmd.op)
						OP_ASSIGN: begin
							to_we = 1'b1;
							to_wa = EW'(cmd.element);
							to_wd = cmd.team;
						end
						OP_DEQ: begin
							if (len_q == '0) begin
								res_push        = 1'b1;
								res.out_element = '0;
								res.was_empty   = 1'b1;
							end
						end
						OP_CLEAR: begin
							head_d  = '0;
							tail_d  = '0;
							len_d   = '0;
							sweep_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ENQ_LOOK: begin
				t_d   = to_rd;
				tt_ra = TW'(to_rd);
				tc_ra = TW'(to_rd);
			end
			ST_ENQ_LINK: begin
				y_d   = tt_rd;
				nl_ra = EW'(tt_rd);
				if (!ins) begin
					if (len_q == '0) begin
						head_d = x_q;
					end else begin
						nl_we = 1'b1;
						nl_wa = EW'(tail_q);
						nl_wd = x_q;
					end
					tail_d = x_q;
				end
				if (t_valid) begin
					tt_we = 1'b1;
					tt_wa = TW'(t_q);
					tt_wd = x_q;
					tc_we = 1'b1;
					tc_wa = TW'(t_q);
					tc_wd = (tc_rd < COUNT_MAX) ? tc_rd + CNT_W'(1) : tc_rd;
				end
				len_d = len_q + LEN_W'(1);
			end
			ST_ENQ_FIX: begin
				nl_we = 1'b1;
				nl_wa = EW'(x_q);
				nl_wd = nl_rd;
			end
			ST_ENQ_SPLICE: begin
				nl_we = 1'b1;
				nl_wa = EW'(y_q);
				nl_wd = x_q;
			end
			ST_DEQ_LOOK: begin
				t_d   = to_rd;
				nxt_d = nl_rd;
				tc_ra = TW'(to_rd);
			end
			ST_DEQ_DONE: begin
				if (t_valid && (tc_rd != '0)) begin
					tc_we = 1'b1;
					tc_wa = TW'(t_q);
					tc_wd = tc_rd - CNT_W'(1);
				end
				head_d = (len_q > LEN_W'(1)) ? nxt_q : '0;
				len_d  = len_q - LEN_W'(1);
				if (len_q == LEN_W'(1)) begin
					tail_d = '0;
				end
				res_push        = 1'b1;
				res.out_element = head_q;
				res.was_empty   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_d;
		y_q   <= y_d;
		t_q   <= t_d;
		nxt_q <= nxt_d;
	end

endmodule

// ----- src/tq_resq.sv -----
// tq_resq: two-entry result queue between the engine and the output side.
// Depends on tq_pkg.
module tq_resq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tq_pkg::res_t din,
	output logic         full,
	output logic         empty,
	input  logic         pop,
	output tq_pkg::res_t dout
);
	import tq_pkg::*;

	res_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       wr;
	logic       rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
		end
	end

endmodule

// ----- src/team_queue.sv -----
// team_queue: command queue, list engine and result queue.
// A dequeue's word is pushed to the result queue in DEQ_DONE, after DEQ_LOOK, or from IDLE
// as it is taken if the queue is empty. States per word: assign, no-op, empty dequeue and
// full-queue enqueue only IDLE; enqueue ENQ_LOOK, ENQ_LINK, plus ENQ_FIX, ENQ_SPLICE when
// linked into the middle; dequeue DEQ_LOOK, DEQ_DONE. After reset and after every clear
// full stays high while membership and counts are swept to zero.
module team_queue #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                action,
	input  logic [tq_pkg::ELEM_W-1:0] element,
	input  logic [tq_pkg::TEAM_W-1:0] team,
	output logic                      empty,
	input  logic                      pop,
	output logic [tq_pkg::ELEM_W-1:0] out_element,
	output logic                      was_empty
);
	import tq_pkg::*;

	cmd_t cmd;
	res_t res;
	res_t res_out;
	logic cmd_valid;
	logic cmd_pop;
	logic busy;
	logic res_full;
	logic res_push;

	tq_front #(
		.ELEMENTS(ELEMENTS),
		.TEAMS   (TEAMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.action   (action),
		.element  (element),
		.team     (team),
		.busy     (busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tq_back #(
		.ELEMENTS(ELEMENTS),
		.TEAMS   (TEAMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.busy     (busy),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	tq_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.empty (empty),
		.pop   (pop),
		.dout  (res_out)
	);

	assign out_element = res_out.out_element;
	assign was_empty   = res_out.was_empty;

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for team_queue; mirrors the linked-list team queue to predict
// every dequeue word and checks the result side against it. Needs tq_pkg and team_queue.
`timescale 1ns / 100ps
module tb;
	import tq_pkg::*;

	localparam int WATCHDOG     = 8000;
	localparam int RANDOM_WORDS = 1320;
	localparam int CHAIN_WORDS  = 100;
	localparam int SETTLE       = 1100;

	typedef struct {
		logic [1:0]        act;
		logic [ELEM_W-1:0] el;
		logic [TEAM_W-1:0] tm;
		int                gap;
	} word_t;

	typedef struct {
		res_t res;
		int   seq;
	} due_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              pop = 1'b0;
	logic [1:0]        action = ACT_ASSIGN;
	logic [ELEM_W-1:0] element = '0;
	logic [TEAM_W-1:0] team = '0;
	logic              full, empty, was_empty;
	logic [ELEM_W-1:0] out_element;

	team_queue dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.element(element), .team(team), .empty(empty), .pop(pop),
		.out_element(out_element), .was_empty(was_empty)
	);

	// mirror of the list state
	bit   [TEAM_W-1:0] team_map     [ELEMENTS_DEF];
	logic [ELEM_W-1:0] link_of      [ELEMENTS_DEF];
	bit                link_set     [ELEMENTS_DEF];
	int                times_queued [ELEMENTS_DEF];
	logic [ELEM_W-1:0] last_of_team [TEAMS_DEF];
	bit                last_set     [TEAMS_DEF];
	bit   [CNT_W-1:0]  team_members [TEAMS_DEF];
	bit   [ELEM_W-1:0] head_el, tail_el;
	bit   [LEN_W-1:0]  depth;

	word_t     cmd_backlog[$];
	due_word_t dequeues_due[$];
	word_t     drv_word;
	due_word_t want;
	int        n_gen = 0, n_sent = 0, n_out = 0, n_empty_out = 0, n_fail = 0;
	int        peak_depth = 0, send_calm = 0, take_calm = 0, pop_hold = 0, idle_cycles = 0;
	int        take_gap = 0;

	function automatic void apply_action(input logic [1:0] a, input logic [ELEM_W-1:0] e,
			input logic [TEAM_W-1:0] t, output bit has, output res_t r);
		bit   [TEAM_W-1:0] tm;
		logic [ELEM_W-1:0] y;
		has = 1'b0;
		r = '0;
		case (a)
		ACT_ASSIGN: team_map[e] = t;
		ACT_ENQUEUE: if (depth < QLEN_MAX) begin
			tm = team_map[e];
			if (tm != 0 && team_members[tm] != 0 && depth != 0 &&
					last_of_team[tm] != tail_el) begin
				y = last_of_team[tm];
				link_of[e] = link_of[y];
				link_set[e] = 1'b1;
				link_of[y] = e;
				link_set[y] = 1'b1;
			end else begin
				if (depth != 0) begin
					link_of[tail_el] = e;
					link_set[tail_el] = 1'b1;
				end else begin
					head_el = e;
				end
				tail_el = e;
			end
			if (tm != 0) begin
				last_of_team[tm] = e;
				last_set[tm] = 1'b1;
				if (team_members[tm] < COUNT_MAX)
					team_members[tm]++;
			end
			depth++;
			times_queued[e]++;
		end
		ACT_DEQUEUE: begin
			has = 1'b1;
			if (depth == 0) begin
				r.was_empty = 1'b1;
			end else begin
				y = head_el;
				tm = team_map[y];
				if (tm != 0 && team_members[tm] != 0)
					team_members[tm]--;
				head_el = (depth > 1) ? link_of[y] : '0;
				depth--;
				if (depth == 0)
					tail_el = '0;
				times_queued[y]--;
				r.out_element = y;
			end
		end
		ACT_CLEAR: begin
			team_map = '{default: '0};
			team_members = '{default: '0};
			times_queued = '{default: 0};
			head_el = '0;
			tail_el = '0;
			depth = '0;
		end
		endcase
	endfunction

	// true when the word would follow a link or team tail that was never written
	function automatic bit reads_unwritten(input logic [1:0] a, input logic [ELEM_W-1:0] e);
		bit [TEAM_W-1:0] tm;
		tm = team_map[e];
		if (a == ACT_ENQUEUE && depth < QLEN_MAX && depth != 0 && tm != 0 &&
				team_members[tm] != 0)
			return !last_set[tm] ||
				(last_of_team[tm] != tail_el && !link_set[last_of_team[tm]]);
		return a == ACT_DEQUEUE && depth > 1 && !link_set[head_el];
	endfunction

	function automatic int idle_draw(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic void note_mismatch(input string msg);
		n_fail++;
		$error("%s", msg);
	endfunction

	task automatic send(input logic [1:0] a, input logic [ELEM_W-1:0] e,
			input logic [TEAM_W-1:0] t);
		word_t     w;
		due_word_t d;
		bit        has;
		res_t      r;
		apply_action(a, e, t, has, r);
		if (has) begin
			d.res = r;
			d.seq = n_gen;
			dequeues_due.insert(dequeues_due.size(), d);
		end
		w.act = a;
		w.el = e;
		w.tm = t;
		w.gap = idle_draw(send_calm);
		cmd_backlog.insert(cmd_backlog.size(), w);
		n_gen++;
		if (int'(depth) > peak_depth)
			peak_depth = int'(depth);
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || push || dequeues_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= ACT_ASSIGN;
			element <= '0;
			team <= '0;
			n_sent <= 0;
		end else begin
			if (push && !full)
				n_sent <= n_sent + 1;
			if (!push || !full) begin
				if (cmd_backlog.size() == 0) begin
					push <= 1'b0;
				end else if (cmd_backlog[0].gap != 0) begin
					cmd_backlog[0].gap = cmd_backlog[0].gap - 1;
					push <= 1'b0;
				end else begin
					drv_word = cmd_backlog.pop_front();
					push <= 1'b1;
					action <= drv_word.act;
					element <= drv_word.el;
					team <= drv_word.tm;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_hold <= 0;
		end else if (pop && !empty) begin
			n_out++;
			if (was_empty)
				n_empty_out++;
			if (dequeues_due.size() == 0 || dequeues_due[0].seq >= n_sent) begin
				note_mismatch($sformatf("word out with no dequeue pending: out_element %0d was_empty %0b",
					out_element, was_empty));
			end else begin
				want = dequeues_due.pop_front();
				if (out_element !== want.res.out_element)
					note_mismatch($sformatf("out_element: expected %0d, got %0d",
						want.res.out_element, out_element));
				if (was_empty !== want.res.was_empty)
					note_mismatch($sformatf("was_empty: expected %0b, got %0b",
						want.res.was_empty, was_empty));
			end
			take_gap = idle_draw(take_calm);
			pop_hold <= take_gap;
			pop <= (take_gap == 0);
		end else if (!pop) begin
			if (pop_hold > 1) begin
				pop_hold <= pop_hold - 1;
			end else begin
				pop_hold <= 0;
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int                i, k, tries, r, s, base;
		logic [1:0]        a;
		logic [ELEM_W-1:0] e;
		logic [TEAM_W-1:0] t;

		// directed: empty dequeue, splice, append behind the tail, underflow, clear
		send(ACT_DEQUEUE, '1, '1);
		send(ACT_ASSIGN, '1, '1);
		send(ACT_ASSIGN, 0, 1);
		send(ACT_ASSIGN, 5, 1);
		send(ACT_ASSIGN, 7, 2);
		send(ACT_ASSIGN, 8, '1);
		send(ACT_ENQUEUE, 0, '1);
		send(ACT_ENQUEUE, 9, 0);
		send(ACT_ENQUEUE, 7, 0);
		send(ACT_ENQUEUE, 5, 0);
		send(ACT_ENQUEUE, '1, 0);
		send(ACT_ENQUEUE, 8, 0);
		repeat (7) send(ACT_DEQUEUE, 0, 0);
		send(ACT_ENQUEUE, 4, 0);
		send(ACT_ASSIGN, 4, 3);
		send(ACT_DEQUEUE, 0, 0);
		send(ACT_ENQUEUE, 0, 0);
		send(ACT_CLEAR, 0, 0);
		send(ACT_DEQUEUE, 0, 0);
		wait_drained();

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2)
				wait_drained();
			tries = 0;
			do begin
				r = $urandom_range(0, 99);
				e = ELEM_W'($urandom);
				t = TEAM_W'($urandom);
				if (r < 10) begin
					a = 2'($urandom);
					if (a == ACT_CLEAR && $urandom_range(0, 3) != 0)
						a = ACT_DEQUEUE;
				end else if (r < 11) begin
					a = ACT_CLEAR;
				end else if (r < 65) begin
					a = (r < 30) ? ACT_ASSIGN : ACT_ENQUEUE;
					k = 0;
					do begin
						e = ($urandom_range(0, 9) == 0) ? ELEM_W'($urandom) :
							ELEM_W'($urandom_range(0, 47));
						k++;
					end while (times_queued[e] != 0 && k < 8);
					if (times_queued[e] != 0)
						a = ACT_DEQUEUE;
					s = $urandom_range(0, 19);
					if (s < 3)
						t = '0;
					else if (s < 17)
						t = TEAM_W'($urandom_range(1, 6));
				end else begin
					a = ACT_DEQUEUE;
				end
				tries++;
			end while (reads_unwritten(a, e) && tries < 16);
			if (reads_unwritten(a, e))
				a = ACT_CLEAR;
			send(a, e, t);
		end

		// long successor chain of team-less elements, then drain past empty
		wait_drained();
		send(ACT_CLEAR, '1, '1);
		base = $urandom_range(0, 1023);
		for (i = 0; i < CHAIN_WORDS; i++)
			send(ACT_ENQUEUE, ELEM_W'(base + i), TEAM_W'($urandom));
		for (i = 0; i <= CHAIN_WORDS; i++)
			send(ACT_DEQUEUE, ELEM_W'($urandom), TEAM_W'($urandom));

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d words in and %0d dequeue words out, %0d on an empty queue.",
			n_gen, n_out, n_empty_out);
		$display("Queue depth peaked at %0d, with team splicing, misuse and a long chain driven.",
			peak_depth);
		if (n_fail == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
